[sv/rsw_pkg.sv]
`default_nettype none

package rsw_pkg;

    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 12;
    localparam int COUNT_W   = 16;
    localparam int VERSION_W = 16;
    localparam int ROWS_W    = 7;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    // 12 + 33 * 65535 needs 22 bits.
    localparam int EXPECT_W  = 22;
    localparam int ROWPOS_W  = 6;
    localparam int ORDER_W   = 2;

    localparam int HDR_BYTES  = 12;
    localparam int ROOT_BYTES = 32;
    localparam logic [INDEX_W-1:0] INDEX_MAX = 12'hFFF;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MAGIC   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_VERSION = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TYPE    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_ORDER   = 3'd7;

    localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'd0;
    localparam logic [ORDER_W-1:0] ORD_LESS    = 2'd1;
    localparam logic [ORDER_W-1:0] ORD_GREATER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_END    = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] wire_byte;
        logic              is_last;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [VERSION_W-1:0] version_seen;
        logic [ROWS_W-1:0]    rows_seen;
    } t_out;

    typedef struct packed {
        logic row_en;
        logic clear;
    } t_row_ctl;

    function automatic logic [BYTE_W-1:0] magic_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] v;
        unique case (idx)
            3'd0: v = 8'h5A;
            3'd1: v = 8'h43;
            3'd2: v = 8'h53;
            3'd3: v = 8'h52;
            3'd4: v = 8'h45;
            3'd5: v = 8'h4C;
            3'd6: v = 8'h0D;
            3'd7: v = 8'h0A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/relation_set_wire_checker_unit.sv]
// Relation-set wire image checker.
// Input channel (i_in_valid / o_in_stall, payload i_in): one image byte per
// transaction, with is_last set on the final byte of an image. The 8-byte
// magic, 16-bit version and 16-bit row count are parsed, and each 33-byte
// row (type byte plus 32-byte root) is checked as it streams past.
// Output channel (o_out_valid / i_out_stall, payload o_out): one transaction
// per image, carrying status, version_seen and rows_seen. Version and rows
// are zero unless the status is ok.
// Throughput is one byte per cycle when not stalled; the whole per-byte
// update is a single compare-and-count step between the state registers. The
// result is in the output register in the cycle after the last byte.
// A result waiting in the output register does not block input; only when
// that register is full and the receiver stalls does o_in_stall rise.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
// once and should be made between images. Index values beyond the three
// registers are ignored.
// Reset clears the parse state and output valid and restores the register
// defaults (version 1, types from 1 up to but not including 8). After each
// result the parse state returns to its reset value for the next image.
`default_nettype none

module relation_set_wire_checker_unit #(
    parameter int MAX_ROWS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire rsw_pkg::t_in                  i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output rsw_pkg::t_out                      o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [rsw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rsw_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    logic [rsw_pkg::VERSION_W-1:0] r_exp_version;
    logic [rsw_pkg::BYTE_W-1:0]    r_type_first;
    logic [rsw_pkg::BYTE_W-1:0]    r_type_end;

    logic [rsw_pkg::INDEX_W-1:0]   r_index, n_index;
    logic                          r_magic, n_magic;
    logic [rsw_pkg::VERSION_W-1:0] r_version, n_version;
    logic [rsw_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [rsw_pkg::EXPECT_W-1:0]  r_expected, w_expected;
    logic                          r_over, w_over;

    logic                          w_accept;
    logic                          w_done;
    logic                          w_hdr_end;
    logic [rsw_pkg::EXPECT_W-1:0]  w_calc;
    logic [rsw_pkg::STATUS_W-1:0]  w_row_err;
    logic [rsw_pkg::STATUS_W-1:0]  w_status;
    rsw_pkg::t_row_ctl             w_row_ctl;

    logic                          r_out_valid;
    rsw_pkg::t_out                 r_out;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_done     = w_accept && i_in.is_last;
    assign w_hdr_end  = (r_index == rsw_pkg::INDEX_W'(rsw_pkg::HDR_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= rsw_pkg::VERSION_W'(1);
            r_type_first  <= rsw_pkg::BYTE_W'(1);
            r_type_end    <= rsw_pkg::BYTE_W'(8);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rsw_pkg::CFG_EXP_VERSION: r_exp_version <= i_cfg_data;
                rsw_pkg::CFG_TYPE_FIRST:  r_type_first  <= i_cfg_data[rsw_pkg::BYTE_W-1:0];
                rsw_pkg::CFG_TYPE_END:    r_type_end    <= i_cfg_data[rsw_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Header parse.
    always_comb begin
        n_magic   = r_magic;
        n_version = r_version;
        n_count   = r_count;
        if (r_index < rsw_pkg::INDEX_W'(8)) begin
            if (i_in.wire_byte != rsw_pkg::magic_byte(r_index[2:0])) begin
                n_magic = 1'b0;
            end
        end else if (r_index == rsw_pkg::INDEX_W'(8)) begin
            n_version[7:0] = i_in.wire_byte;
        end else if (r_index == rsw_pkg::INDEX_W'(9)) begin
            n_version[15:8] = i_in.wire_byte;
        end else if (r_index == rsw_pkg::INDEX_W'(10)) begin
            n_count[7:0] = i_in.wire_byte;
        end else if (w_hdr_end) begin
            n_count[15:8] = i_in.wire_byte;
        end
        n_index = (r_index == rsw_pkg::INDEX_MAX) ? r_index
                                                  : r_index + rsw_pkg::INDEX_W'(1);
    end

    // Image length implied by the row count, 12 + 33 * count.
    assign w_calc = rsw_pkg::EXPECT_W'({n_count, 5'b0}) + rsw_pkg::EXPECT_W'(n_count)
                  + rsw_pkg::EXPECT_W'(rsw_pkg::HDR_BYTES);
    assign w_expected = w_hdr_end ? w_calc : r_expected;
    assign w_over     = w_hdr_end ? (n_count > rsw_pkg::COUNT_W'(MAX_ROWS)) : r_over;

    assign w_row_ctl.row_en = w_accept
                           && r_index >= rsw_pkg::INDEX_W'(rsw_pkg::HDR_BYTES)
                           && r_index != rsw_pkg::INDEX_MAX
                           && !r_over
                           && rsw_pkg::EXPECT_W'(r_index) < r_expected;
    assign w_row_ctl.clear  = w_done;

    rsw_row_chk u_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_row_ctl),
        .i_byte       (i_in.wire_byte),
        .i_type_first (r_type_first),
        .i_type_end   (r_type_end),
        .o_first_err  (w_row_err)
    );

    always_comb begin
        priority if (n_index < rsw_pkg::INDEX_W'(rsw_pkg::HDR_BYTES)) begin
            w_status = rsw_pkg::ST_SIZE;
        end else if (!n_magic) begin
            w_status = rsw_pkg::ST_MAGIC;
        end else if (w_over) begin
            w_status = rsw_pkg::ST_LIMIT;
        end else if (rsw_pkg::EXPECT_W'(n_index) != w_expected) begin
            w_status = rsw_pkg::ST_SIZE;
        end else if (n_version != r_exp_version) begin
            w_status = rsw_pkg::ST_VERSION;
        end else begin
            w_status = w_row_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_done) begin
            r_index    <= '0;
            r_magic    <= 1'b1;
            r_version  <= '0;
            r_count    <= '0;
            r_expected <= rsw_pkg::EXPECT_W'(rsw_pkg::HDR_BYTES);
            r_over     <= 1'b0;
        end else if (w_accept) begin
            r_index    <= n_index;
            r_magic    <= n_magic;
            r_version  <= n_version;
            r_count    <= n_count;
            r_expected <= w_expected;
            r_over     <= w_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out.status       <= w_status;
            r_out.version_seen <= (w_status == rsw_pkg::ST_OK) ? n_version : '0;
            r_out.rows_seen    <= (w_status == rsw_pkg::ST_OK) ? n_count[rsw_pkg::ROWS_W-1:0]
                                                               : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

[sv/rsw_row_chk.sv]
`default_nettype none

module rsw_row_chk (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rsw_pkg::t_row_ctl           i_ctl,
    input  wire logic [rsw_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic [rsw_pkg::BYTE_W-1:0]  i_type_first,
    input  wire logic [rsw_pkg::BYTE_W-1:0]  i_type_end,
    output logic      [rsw_pkg::STATUS_W-1:0] o_first_err
);

    logic [rsw_pkg::ROWPOS_W-1:0] r_pos, n_pos;
    logic [rsw_pkg::BYTE_W-1:0]   r_cur_type, n_cur_type;
    logic [rsw_pkg::BYTE_W-1:0]   r_prev_type, n_prev_type;
    logic [rsw_pkg::ORDER_W-1:0]  r_order, n_order;
    logic                         r_nz, n_nz;
    logic                         r_have_prev, n_have_prev;
    logic [rsw_pkg::STATUS_W-1:0] r_err, n_err;
    // Previous root as a shift line: each root byte leaves at tap 0 as the
    // matching byte of the new row enters at the far end.
    logic [rsw_pkg::BYTE_W-1:0]   r_root [rsw_pkg::ROOT_BYTES];
    logic [rsw_pkg::BYTE_W-1:0]   w_tap;
    logic                         w_shift;

    assign w_tap   = r_root[0];
    assign w_shift = i_ctl.row_en && (r_pos != '0);

    always_comb begin
        n_pos       = r_pos;
        n_cur_type  = r_cur_type;
        n_prev_type = r_prev_type;
        n_order     = r_order;
        n_nz        = r_nz;
        n_have_prev = r_have_prev;
        n_err       = r_err;
        if (i_ctl.row_en) begin
            if (r_pos == '0) begin
                n_cur_type = i_byte;
                if ((i_byte < i_type_first || i_byte >= i_type_end) &&
                    r_err == rsw_pkg::ST_OK) begin
                    n_err = rsw_pkg::ST_TYPE;
                end
                n_order = rsw_pkg::ORD_EQUAL;
                n_nz    = 1'b0;
                n_pos   = rsw_pkg::ROWPOS_W'(1);
            end else begin
                if (i_byte != '0) begin
                    n_nz = 1'b1;
                end
                if (r_have_prev && r_order == rsw_pkg::ORD_EQUAL && w_tap != i_byte) begin
                    n_order = (w_tap < i_byte) ? rsw_pkg::ORD_LESS : rsw_pkg::ORD_GREATER;
                end
                if (r_pos < rsw_pkg::ROWPOS_W'(rsw_pkg::ROOT_BYTES)) begin
                    n_pos = r_pos + rsw_pkg::ROWPOS_W'(1);
                end else begin
                    if (r_err == rsw_pkg::ST_OK) begin
                        if (!n_nz) begin
                            n_err = rsw_pkg::ST_ZERO;
                        end else if (r_have_prev &&
                                     (r_prev_type > r_cur_type ||
                                      (r_prev_type == r_cur_type &&
                                       n_order != rsw_pkg::ORD_LESS))) begin
                            n_err = rsw_pkg::ST_ORDER;
                        end
                    end
                    n_prev_type = r_cur_type;
                    n_have_prev = 1'b1;
                    n_pos       = '0;
                end
            end
        end
    end

    assign o_first_err = n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_pos       <= '0;
            r_cur_type  <= '0;
            r_prev_type <= '0;
            r_order     <= rsw_pkg::ORD_EQUAL;
            r_nz        <= 1'b0;
            r_have_prev <= 1'b0;
            r_err       <= rsw_pkg::ST_OK;
        end else begin
            r_pos       <= n_pos;
            r_cur_type  <= n_cur_type;
            r_prev_type <= n_prev_type;
            r_order     <= n_order;
            r_nz        <= n_nz;
            r_have_prev <= n_have_prev;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            for (int j = 0; j < rsw_pkg::ROOT_BYTES - 1; j++) begin
                r_root[j] <= r_root[j+1];
            end
            r_root[rsw_pkg::ROOT_BYTES-1] <= i_byte;
        end
    end

endmodule

`default_nettype wire

[sv/rsw_checker.sv]
`default_nettype none

module rsw_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_stall,
    input  wire rsw_pkg::t_in                  i_in,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire rsw_pkg::t_out                 o_out
);

    // A result held back by the receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed or vanished while stalled");

    // A last byte taken always yields a result in the next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.is_last |=> o_out_valid)
        else $error("last byte accepted without a result");

    // A fresh result only follows an accepted last byte.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_in.is_last))
        else $error("result appeared without a last byte");

    // Failed images report no version and no rows.
    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != rsw_pkg::ST_OK
            |-> o_out.version_seen == '0 && o_out.rows_seen == '0)
        else $error("error status carries nonzero fields");

endmodule

bind relation_set_wire_checker_unit rsw_checker u_rsw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

[tb/sv/relation_set_wire_checker_unit_tb.sv]
`timescale 1ns / 1ps

module relation_set_wire_checker_unit_tb;

    localparam int MAX_ROWS    = 64;
    localparam int ROW_LEN     = 33;
    localparam int LEN_CAP     = 4095;
    localparam int VER_AT      = 8;
    localparam int CNT_AT      = 10;
    localparam logic [63:0] MAGIC_WORD = 64'h5A43_5352_454C_0D0A;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        IMG_GOOD, IMG_MAGIC, IMG_VERSION, IMG_LIMIT, IMG_SHORT,
        IMG_LONG, IMG_TYPE, IMG_ZERO, IMG_ORDER, IMG_TINY
    } t_image_kind;

    // Follows one image byte by byte and keeps the status words that the
    // block must return, oldest first.
    class t_wire_status_board;
        logic [rsw_pkg::VERSION_W-1:0] exp_version;
        logic [7:0]                    type_lo;
        logic [7:0]                    type_hi;
        int                            n_bytes;
        bit                            magic_ok;
        logic [rsw_pkg::VERSION_W-1:0] ver_acc;
        logic [rsw_pkg::COUNT_W-1:0]   cnt_acc;
        int                            row_off;
        logic [7:0]                    cur_ty;
        logic [7:0]                    prev_ty;
        logic [rsw_pkg::ORDER_W-1:0]   root_cmp;
        bit                            root_nz;
        bit                            have_prev;
        logic [rsw_pkg::STATUS_W-1:0]  row_err;
        logic [7:0]                    last_root [rsw_pkg::ROOT_BYTES];
        rsw_pkg::t_out                 status_q [$];
        int                            errors;

        function new();
            exp_version = 16'd1;
            type_lo = 8'd1;
            type_hi = 8'd8;
            foreach (last_root[k]) last_root[k] = 8'h00;
            errors = 0;
            restart();
        endfunction

        function void restart();
            n_bytes = 0;
            magic_ok = 1'b1;
            ver_acc = '0;
            cnt_acc = '0;
            row_off = 0;
            cur_ty = '0;
            prev_ty = '0;
            root_cmp = rsw_pkg::ORD_EQUAL;
            root_nz = 1'b0;
            have_prev = 1'b0;
            row_err = rsw_pkg::ST_OK;
        endfunction

        function void set_reg(logic [rsw_pkg::CFG_IDX_W-1:0] idx,
                              logic [rsw_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                rsw_pkg::CFG_EXP_VERSION: exp_version = data;
                rsw_pkg::CFG_TYPE_FIRST:  type_lo = data[7:0];
                rsw_pkg::CFG_TYPE_END:    type_hi = data[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void take_row_byte(logic [7:0] b);
            int k;
            if (row_off == 0) begin
                cur_ty = b;
                if ((b < type_lo || b >= type_hi) && row_err == rsw_pkg::ST_OK)
                    row_err = rsw_pkg::ST_TYPE;
                root_cmp = rsw_pkg::ORD_EQUAL;
                root_nz = 1'b0;
                row_off = 1;
            end else begin
                k = row_off - 1;
                if (b != 8'h00) root_nz = 1'b1;
                // The first differing root byte decides the order against the last row.
                if (have_prev && root_cmp == rsw_pkg::ORD_EQUAL && last_root[k] != b)
                    root_cmp = (last_root[k] < b) ? rsw_pkg::ORD_LESS : rsw_pkg::ORD_GREATER;
                last_root[k] = b;
                if (row_off < rsw_pkg::ROOT_BYTES) begin
                    row_off++;
                end else begin
                    if (row_err == rsw_pkg::ST_OK) begin
                        if (!root_nz)
                            row_err = rsw_pkg::ST_ZERO;
                        else if (have_prev && (prev_ty > cur_ty ||
                                 (prev_ty == cur_ty && root_cmp != rsw_pkg::ORD_LESS)))
                            row_err = rsw_pkg::ST_ORDER;
                    end
                    prev_ty = cur_ty;
                    have_prev = 1'b1;
                    row_off = 0;
                end
            end
        endfunction

        function void note_byte(rsw_pkg::t_in item);
            int i;
            int len;
            logic [rsw_pkg::STATUS_W-1:0] st;
            rsw_pkg::t_out r;
            i = n_bytes;
            if (i < 8) begin
                if (item.wire_byte != MAGIC_WORD[8*(7-i) +: 8]) magic_ok = 1'b0;
            end else if (i == VER_AT) begin
                ver_acc[7:0] = item.wire_byte;
            end else if (i == VER_AT + 1) begin
                ver_acc[15:8] = item.wire_byte;
            end else if (i == CNT_AT) begin
                cnt_acc[7:0] = item.wire_byte;
            end else if (i == CNT_AT + 1) begin
                cnt_acc[15:8] = item.wire_byte;
            end else if (i < LEN_CAP && cnt_acc <= MAX_ROWS &&
                         i - rsw_pkg::HDR_BYTES < ROW_LEN * int'(cnt_acc)) begin
                take_row_byte(item.wire_byte);
            end
            len = (i < LEN_CAP) ? i + 1 : LEN_CAP;
            n_bytes = len;
            if (item.is_last) begin
                if (len < rsw_pkg::HDR_BYTES) st = rsw_pkg::ST_SIZE;
                else if (!magic_ok) st = rsw_pkg::ST_MAGIC;
                else if (cnt_acc > MAX_ROWS) st = rsw_pkg::ST_LIMIT;
                else if (len != rsw_pkg::HDR_BYTES + ROW_LEN * int'(cnt_acc))
                    st = rsw_pkg::ST_SIZE;
                else if (ver_acc != exp_version) st = rsw_pkg::ST_VERSION;
                else st = row_err;
                r.status = st;
                r.version_seen = (st == rsw_pkg::ST_OK) ? ver_acc : '0;
                r.rows_seen = (st == rsw_pkg::ST_OK) ? cnt_acc[rsw_pkg::ROWS_W-1:0] : '0;
                status_q.push_back(r);
                restart();
            end
        endfunction

        function void check_status(rsw_pkg::t_out got);
            rsw_pkg::t_out want;
            if (status_q.size() == 0) begin
                $error("status: expected no transaction, got %0d", got.status);
                errors++;
            end else begin
                want = status_q.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.version_seen !== want.version_seen) begin
                    $error("version_seen: expected %0d, got %0d",
                           want.version_seen, got.version_seen);
                    errors++;
                end
                if (got.rows_seen !== want.rows_seen) begin
                    $error("rows_seen: expected %0d, got %0d", want.rows_seen, got.rows_seen);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    rsw_pkg::t_in                  i_in = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    rsw_pkg::t_out                 o_out;
    logic                          i_cfg_we = 1'b0;
    logic [rsw_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rsw_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;

    t_wire_status_board board;
    logic [7:0] img [$];
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    relation_set_wire_checker_unit #(
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A requested hold-off keeps the receiver stalled for a long stretch.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Results are checked before the same edge's input byte is noted.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_status(o_out);
        if (i_rst_n && i_in_valid && !o_in_stall) board.note_byte(i_in);
        if (i_rst_n && ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("relation_set_wire_checker_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in.wire_byte <= b;
        i_in.is_last <= last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_image();
        foreach (img[k]) send_byte(img[k], k == img.size() - 1);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] ver, logic [7:0] lo, logic [7:0] hi);
        logic [rsw_pkg::CFG_DAT_W-1:0] lo_word;
        logic [rsw_pkg::CFG_DAT_W-1:0] hi_word;
        // The upper byte of a type write carries junk that must be dropped.
        lo_word = {8'($urandom), lo};
        hi_word = {8'($urandom), hi};
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= rsw_pkg::CFG_EXP_VERSION;
        i_cfg_data <= ver;
        @(posedge i_clk);
        board.set_reg(rsw_pkg::CFG_EXP_VERSION, ver);
        i_cfg_index <= rsw_pkg::CFG_TYPE_FIRST;
        i_cfg_data <= lo_word;
        @(posedge i_clk);
        board.set_reg(rsw_pkg::CFG_TYPE_FIRST, lo_word);
        i_cfg_index <= rsw_pkg::CFG_TYPE_END;
        i_cfg_data <= hi_word;
        @(posedge i_clk);
        board.set_reg(rsw_pkg::CFG_TYPE_END, hi_word);
        i_cfg_we <= 1'b0;
    endtask

    // Builds an image for the current settings; with a nonempty type range it is
    // well-formed: row types do not descend, and a row that repeats a type gets a larger root.
    function automatic void build_image(int n_rows, bit one_type);
        logic [7:0] root [rsw_pkg::ROOT_BYTES];
        int ty;
        int last_ty;
        int lo;
        int hi;
        int p;
        lo = board.type_lo;
        hi = board.type_hi;
        img.delete();
        for (int k = 0; k < 8; k++) img.push_back(MAGIC_WORD[8*(7-k) +: 8]);
        img.push_back(board.exp_version[7:0]);
        img.push_back(board.exp_version[15:8]);
        img.push_back(8'(n_rows));
        img.push_back(8'(n_rows >> 8));
        ty = (hi > lo) ? $urandom_range(lo, lo + (hi - lo - 1) / 4) : 0;
        last_ty = ty;
        foreach (root[q]) root[q] = 8'h00;
        for (int r = 0; r < n_rows; r++) begin
            if (hi <= lo)
                ty = $urandom_range(0, 255);
            else if (r > 0 && !one_type && $urandom_range(0, 2) == 0 && ty < hi - 1)
                ty = $urandom_range(ty + 1, hi - 1);
            if (r == 0 || ty != last_ty) begin
                foreach (root[q]) root[q] = 8'($urandom);
            end else begin
                p = $urandom_range(0, rsw_pkg::ROOT_BYTES - 1);
                while (p > 0 && root[p] == 8'hFF) p--;
                root[p] = 8'($urandom_range(root[p] + 1, 255));
                for (int q = p + 1; q < rsw_pkg::ROOT_BYTES; q++) root[q] = 8'($urandom);
            end
            last_ty = ty;
            img.push_back(8'(ty));
            foreach (root[q]) img.push_back(root[q]);
        end
    endfunction

    function automatic void mutate(t_image_kind kind);
        int n_rows;
        int r;
        int v;
        int base;
        n_rows = (img.size() - rsw_pkg::HDR_BYTES) / ROW_LEN;
        r = (n_rows > 0) ? $urandom_range(0, n_rows - 1) : 0;
        base = rsw_pkg::HDR_BYTES + ROW_LEN * r;
        case (kind)
            IMG_MAGIC: begin
                v = $urandom_range(0, 7);
                img[v] = img[v] ^ (8'h01 << $urandom_range(0, 7));
            end
            IMG_VERSION: begin
                v = VER_AT + $urandom_range(0, 1);
                img[v] = img[v] ^ 8'($urandom_range(1, 255));
            end
            IMG_LIMIT: begin
                v = $urandom_range(MAX_ROWS + 1, 65535);
                img[CNT_AT] = v[7:0];
                img[CNT_AT + 1] = v[15:8];
            end
            IMG_SHORT: begin
                repeat ($urandom_range(1, (img.size() > 40) ? 40 : img.size() - 1))
                    void'(img.pop_back());
            end
            IMG_LONG: begin
                repeat ($urandom_range(1, 40)) img.push_back(8'($urandom));
            end
            IMG_TYPE: begin
                if (n_rows > 0) begin
                    if (board.type_lo > 0 && $urandom_range(0, 1))
                        img[base] = 8'($urandom_range(0, board.type_lo - 1));
                    else
                        img[base] = 8'($urandom_range(board.type_hi, 255));
                end
            end
            IMG_ZERO: begin
                if (n_rows > 0)
                    for (int q = 1; q <= rsw_pkg::ROOT_BYTES; q++) img[base + q] = 8'h00;
            end
            IMG_ORDER: begin
                // Repeating the previous row breaks the strict ordering.
                if (n_rows > 1) begin
                    if (r == 0) base = base + ROW_LEN;
                    for (int q = 0; q < ROW_LEN; q++) img[base + q] = img[base - ROW_LEN + q];
                end
            end
            IMG_TINY: begin
                v = $urandom_range(1, rsw_pkg::HDR_BYTES - 1);
                while (img.size() > v) void'(img.pop_back());
                if ($urandom_range(0, 1)) foreach (img[q]) img[q] = 8'($urandom);
            end
            default: ;
        endcase
    endfunction

    task automatic run_image(int n_rows, bit one_type, t_image_kind kind);
        build_image(n_rows, one_type);
        mutate(kind);
        send_image();
    endtask

    initial begin
        int phase_bytes;
        int phase_imgs;
        int lo;
        t_image_kind kind;
        board = new();
        send_idle_pct = 31;
        stall_pct = 72;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed images under the reset settings.
        run_image(0, 0, IMG_GOOD);
        run_image(1, 0, IMG_GOOD);
        run_image(5, 1, IMG_GOOD);
        build_image(0, 0);
        img = img[0:0];
        send_image();
        build_image(0, 0);
        img = img[0:rsw_pkg::HDR_BYTES - 2];
        send_image();
        build_image(0, 0);
        img[7] = 8'h0B;
        send_image();
        build_image(0, 0);
        img[CNT_AT] = 8'(MAX_ROWS + 1);
        send_image();
        build_image(0, 0);
        img[CNT_AT] = 8'hFF;
        img[CNT_AT + 1] = 8'hFF;
        send_image();
        // A count right at the limit passes the limit check and fails on length.
        build_image(0, 0);
        img[CNT_AT] = 8'(MAX_ROWS);
        send_image();
        build_image(1, 0);
        void'(img.pop_back());
        send_image();
        build_image(1, 0);
        img.push_back(8'hFF);
        send_image();
        build_image(0, 0);
        img[VER_AT] = 8'h00;
        send_image();
        build_image(1, 0);
        img[rsw_pkg::HDR_BYTES] = 8'h00;
        send_image();
        build_image(2, 0);
        img[rsw_pkg::HDR_BYTES + ROW_LEN] = board.type_hi;
        send_image();
        build_image(1, 0);
        img[rsw_pkg::HDR_BYTES] = 8'hFF;
        send_image();
        run_image(2, 0, IMG_ZERO);
        run_image(2, 1, IMG_ORDER);
        build_image(2, 0);
        img[rsw_pkg::HDR_BYTES] = 8'd7;
        img[rsw_pkg::HDR_BYTES + ROW_LEN] = 8'd2;
        send_image();
        // A zero root in the first row outranks a type error in the second.
        build_image(2, 0);
        for (int q = 1; q <= rsw_pkg::ROOT_BYTES; q++) img[rsw_pkg::HDR_BYTES + q] = 8'h00;
        img[rsw_pkg::HDR_BYTES + ROW_LEN] = 8'h00;
        send_image();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_config(16'd1, 8'd1, 8'd8);
                1: set_config(16'h0000, 8'd0, 8'd255);
                2: set_config(16'hFFFF, 8'd255, 8'd0);
                4: set_config(16'h1234, 8'd3, 8'd3);
                5: set_config(16'd1, 8'd0, 8'd1);
                6: set_config(16'hFFFF, 8'd254, 8'd255);
                8: set_config(16'd1, 8'd1, 8'd8);
                default: begin
                    lo = $urandom_range(0, 200);
                    set_config(16'($urandom), 8'(lo), 8'(lo + $urandom_range(1, 40)));
                end
            endcase
            send_idle_pct = (ph < 3) ? 31 : (ph < 6) ? 72 : 0;
            stall_pct = (ph < 3) ? 72 : (ph < 6) ? 31 : 0;
            if (ph == 6) hold_req = 1'b1;
            phase_bytes = 0;
            phase_imgs = 0;
            // During the hold-off several images follow each other so that the
            // waiting result stalls the input.
            while (phase_bytes < 30 || phase_imgs < ((ph == 6) ? 3 : 1)) begin
                kind = $urandom_range(0, 1) ? IMG_GOOD :
                       t_image_kind'($urandom_range(int'(IMG_MAGIC), int'(IMG_TINY)));
                run_image(($urandom_range(0, 7) == 0) ? $urandom_range(3, 5)
                                                      : $urandom_range(0, 2),
                          $urandom_range(0, 3) == 0, kind);
                phase_bytes += img.size();
                phase_imgs++;
                if (ph == 4 && phase_imgs == 1) drain();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("relation_set_wire_checker_unit_tb OK");
        else
            $display("relation_set_wire_checker_unit_tb NOT OK");
        $finish;
    end

endmodule

[relation_set_wire_checker_unit.f]
sv/rsw_pkg.sv
sv/rsw_row_chk.sv
sv/relation_set_wire_checker_unit.sv
sv/rsw_checker.sv
tb/sv/relation_set_wire_checker_unit_tb.sv
